/* hdl/sha1s_pkg.sv */
`timescale 1ns / 1ps

package sha1s_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       finish;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [1:0] {
    BSEL_IN,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      push;
    byte_sel_t byte_sel;
    logic      count_inc;
    logic      round_en;
    logic      expand;
    logic [1:0] stage;
    logic      fold;
    logic      emit;
    logic [2:0] emit_idx;
    logic      restart;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_valid;
  } status_t;

  localparam logic [4:0][31:0] INIT_H = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] BLOCK_LAST  = 6'd63;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [6:0] ROUND_LAST  = 7'd79;
  localparam logic [6:0] SCHED_WORDS = 7'd16;
  localparam logic [2:0] WORD_LAST   = 3'd4;

  localparam logic [1:0] STAGE_CH  = 2'd0;
  localparam logic [1:0] STAGE_P1  = 2'd1;
  localparam logic [1:0] STAGE_MAJ = 2'd2;
  localparam logic [1:0] STAGE_P2  = 2'd3;

  function automatic logic [31:0] round_k(input logic [1:0] stage);
    logic [31:0] k;
    case (stage)
      STAGE_CH:  k = 32'h5a827999;
      STAGE_P1:  k = 32'h6ed9eba1;
      STAGE_MAJ: k = 32'h8f1bbcdc;
      default:   k = 32'hca62c1d6;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] stage, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (stage)
      STAGE_CH:  f = d ^ (b & (c ^ d));
      STAGE_MAJ: f = (b & c) | (d & (b | c));
      default:   f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

/* hdl/sha1s_datapath.sv */
`timescale 1ns / 1ps

module sha1s_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_byte,
  input  sha1s_pkg::cmd_t     cmd,
  input  logic                out_stall,
  output sha1s_pkg::status_t  status,
  output logic                out_valid,
  output sha1s_pkg::out_item_t out_data
);

  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] chain_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] count_r;
  logic [5:0]  fill_r;
  logic        out_valid_r;
  sha1s_pkg::out_item_t out_data_r;

  logic [7:0]  push_byte;
  logic [63:0] len_bits;
  logic [2:0]  len_k;
  logic [31:0] mix;
  logic [31:0] wt;
  logic [31:0] temp;
  logic        block_done;

  assign len_bits = {29'd0, count_r, 3'd0};
  assign len_k    = 3'd7 - fill_r[2:0];

  always_comb begin
    case (cmd.byte_sel)
      sha1s_pkg::BSEL_IN:   push_byte = in_byte;
      sha1s_pkg::BSEL_PAD:  push_byte = sha1s_pkg::PAD_BYTE;
      sha1s_pkg::BSEL_ZERO: push_byte = 8'd0;
      default:              push_byte = len_bits[{len_k, 3'b000} +: 8];
    endcase
  end

  assign mix  = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign wt   = cmd.expand ? {mix[30:0], mix[31]} : w_r[0];
  assign temp = {a_r[26:0], a_r[31:27]} + sha1s_pkg::round_f(cmd.stage, b_r, c_r, d_r)
              + e_r + sha1s_pkg::round_k(cmd.stage) + wt;

  assign block_done = cmd.push && (fill_r == sha1s_pkg::BLOCK_LAST);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      w_nxt[i] = w_r[i];
    end
    if (cmd.push) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = {w_r[i][23:0], w_r[i + 1][31:24]};
      end
      w_nxt[15] = {w_r[15][23:0], push_byte};
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i + 1];
      end
      w_nxt[15] = wt;
    end
  end

  // message block, working variables and output word
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      w_r[i] <= w_nxt[i];
    end
    if (block_done) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.round_en) begin
      a_r <= temp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
    if (cmd.emit) begin
      out_data_r.digest_word <= chain_r[cmd.emit_idx];
      out_data_r.word_index  <= cmd.emit_idx;
      out_data_r.last_word   <= (cmd.emit_idx == sha1s_pkg::WORD_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= sha1s_pkg::INIT_H[i];
      end
      count_r     <= 32'd0;
      fill_r      <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.restart) begin
        for (int i = 0; i < 5; i++) begin
          chain_r[i] <= sha1s_pkg::INIT_H[i];
        end
        count_r <= 32'd0;
        fill_r  <= 6'd0;
      end else begin
        if (cmd.fold) begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          chain_r[4] <= chain_r[4] + e_r;
        end
        if (cmd.count_inc) begin
          count_r <= count_r + 32'd1;
        end
        if (cmd.push) begin
          fill_r <= fill_r + 6'd1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.fill      = fill_r;
  assign status.out_valid = out_valid_r;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

endmodule

/* hdl/sha1s_ctrl.sv */
`timescale 1ns / 1ps

module sha1s_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               has_byte,
  input  logic               finish,
  input  logic               out_stall,
  input  sha1s_pkg::status_t status,
  output logic               in_stall,
  output sha1s_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD80,
    ST_PADZ,
    ST_LEN,
    ST_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  state_t     ret_r, ret_nxt;
  logic [6:0] round_r, round_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       block_end;

  assign block_end = (status.fill == sha1s_pkg::BLOCK_LAST);
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    round_nxt    = round_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.byte_sel = sha1s_pkg::BSEL_IN;
    cmd.emit_idx = idx_r;
    cmd.expand   = (round_r >= sha1s_pkg::SCHED_WORDS);
    if (round_r < 7'd20) begin
      cmd.stage = sha1s_pkg::STAGE_CH;
    end else if (round_r < 7'd40) begin
      cmd.stage = sha1s_pkg::STAGE_P1;
    end else if (round_r < 7'd60) begin
      cmd.stage = sha1s_pkg::STAGE_MAJ;
    end else begin
      cmd.stage = sha1s_pkg::STAGE_P2;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (has_byte) begin
            cmd.push      = 1'b1;
            cmd.count_inc = 1'b1;
            if (block_end) begin
              state_nxt = ST_ROUND;
              ret_nxt   = finish ? ST_PAD80 : ST_IDLE;
            end else if (finish) begin
              state_nxt = ST_PAD80;
            end
          end else if (finish) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (round_r == sha1s_pkg::ROUND_LAST) begin
          round_nxt = 7'd0;
          state_nxt = ST_FOLD;
        end else begin
          round_nxt = round_r + 7'd1;
        end
      end
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = ret_r;
      end
      ST_PAD80: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = sha1s_pkg::BSEL_PAD;
        if (block_end) begin
          state_nxt = ST_ROUND;
          ret_nxt   = ST_PADZ;
        end else begin
          state_nxt = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (status.fill == sha1s_pkg::LEN_POS) begin
          state_nxt = ST_LEN;
        end else begin
          cmd.push     = 1'b1;
          cmd.byte_sel = sha1s_pkg::BSEL_ZERO;
          if (block_end) begin
            state_nxt = ST_ROUND;
            ret_nxt   = ST_PADZ;
          end
        end
      end
      ST_LEN: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = sha1s_pkg::BSEL_LEN;
        if (block_end) begin
          state_nxt = ST_ROUND;
          ret_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.out_valid || !out_stall) begin
          cmd.emit = 1'b1;
          if (idx_r == sha1s_pkg::WORD_LAST) begin
            cmd.restart = 1'b1;
            idx_nxt     = 3'd0;
            state_nxt   = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      round_r <= 7'd0;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      round_r <= round_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

/* hdl/sha1_stream_hasher.sv */
`timescale 1ns / 1ps
// a byte item is accepted whenever the hasher is idle; the 64th byte of a block then runs
// 80 rounds on one shared round unit plus the chaining add, with the input stalled meanwhile
// finish: pad and length bytes are pushed one per cycle, pausing while a closed block is hashed,
// with a check state at the length slot, then one digest word per cycle unless a pending word is stalled
// throughput is set by the single round unit, as no byte is taken while a block is hashed
// reset (synchronous, rst_n low) loads the initial chaining values and clears counts

module sha1_stream_hasher (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha1s_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha1s_pkg::out_item_t out_data
);

  sha1s_pkg::cmd_t    cmd;
  sha1s_pkg::status_t status;

  sha1s_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .has_byte  (in_data.has_byte),
    .finish    (in_data.finish),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  sha1s_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_data.data_byte),
    .cmd       (cmd),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* dv/sha1_stream_hasher_test.sv */
`timescale 1ns / 1ps

module sha1_stream_hasher_test;

  localparam logic [31:0] K_CH  = 32'h5a827999;
  localparam logic [31:0] K_P1  = 32'h6ed9eba1;
  localparam logic [31:0] K_MAJ = 32'h8f1bbcdc;
  localparam logic [31:0] K_P2  = 32'hca62c1d6;
  localparam logic [5:0]  LEN_SLOT = 6'd56;
  localparam int MAX_GAP = 17;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 370;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sha1s_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sha1s_pkg::out_item_t out_data;

  sha1_stream_hasher uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] hash_h[5];
  logic [31:0] blk_w[16];
  logic [31:0] msg_len;
  logic [5:0]  blk_fill;

  sha1s_pkg::out_item_t digest_q[$];

  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned msgs_done = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches = 0;
  bit tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic rx_hold = 1'b0;
  int unsigned rx_wait = 0;

  function automatic logic [31:0] rol(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void sha1_restart();
    for (int i = 0; i < 5; i++) hash_h[i] = sha1s_pkg::INIT_H[i];
    for (int i = 0; i < 16; i++) blk_w[i] = '0;
    msg_len = '0;
    blk_fill = '0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] a, b, c, d, e, f, w;
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w = blk_w[(r + 13) & 15] ^ blk_w[(r + 8) & 15] ^ blk_w[(r + 2) & 15] ^ blk_w[r & 15];
        blk_w[r & 15] = rol(w, 1);
      end
      if (r < 20) f = (d ^ (b & (c ^ d))) + K_CH;
      else if (r < 40) f = (b ^ c ^ d) + K_P1;
      else if (r < 60) f = ((b & c) | (d & (b | c))) + K_MAJ;
      else f = (b ^ c ^ d) + K_P2;
      f = f + rol(a, 5) + e + blk_w[r & 15];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = f;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endfunction

  function automatic void sha1_push_byte(logic [7:0] byt);
    int shift;
    shift = (3 - blk_fill[1:0]) * 8;
    blk_w[blk_fill[5:2]] = (blk_w[blk_fill[5:2]] & ~(32'hff << shift)) |
                           ({24'b0, byt} << shift);
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) sha1_compress();
  endfunction

  function automatic void sha1_absorb(sha1s_pkg::in_item_t it);
    logic [63:0] bitlen;
    sha1s_pkg::out_item_t word;
    if (it.has_byte) begin
      msg_len = msg_len + 32'd1;
      sha1_push_byte(it.data_byte);
    end
    if (!it.finish) return;
    bitlen = {29'b0, msg_len, 3'b0};
    sha1_push_byte(sha1s_pkg::PAD_BYTE);
    while (blk_fill != LEN_SLOT) sha1_push_byte(8'h00);
    for (int i = 7; i >= 0; i--) sha1_push_byte(bitlen[i*8 +: 8]);
    for (int k = 0; k < 5; k++) begin
      word.digest_word = hash_h[k];
      word.word_index = 3'(k);
      word.last_word = (3'(k) == sha1s_pkg::WORD_LAST);
      digest_q.push_back(word);
    end
    msgs_done++;
    sha1_restart();
  endfunction

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digest words outstanding",
               cycle_cnt, digest_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: per-transaction stall draw plus long hold
  always @(posedge clk) begin
    if (out_valid && !out_stall)
      rx_wait = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    else if (rx_wait > 0)
      rx_wait = rx_wait - 1;
    out_stall <= rx_hold || (rx_wait > 0);
  end

  always @(posedge clk) begin
    sha1s_pkg::out_item_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h idx %0d last %0b",
                   out_data.digest_word, out_data.word_index, out_data.last_word);
      end else begin
        exp_w = digest_q.pop_front();
        words_checked++;
        if (out_data.digest_word !== exp_w.digest_word ||
            out_data.word_index !== exp_w.word_index ||
            out_data.last_word !== exp_w.last_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                     exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                     out_data.digest_word, out_data.word_index, out_data.last_word);
        end
      end
    end
  end

  task automatic send_item(logic [7:0] byt, logic hb, logic fin);
    sha1s_pkg::in_item_t it;
    int gap;
    it.data_byte = byt;
    it.has_byte = hb;
    it.finish = fin;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sha1_absorb(it);
    items_sent++;
  endtask

  task automatic hold_receiver(int cycles);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
  endtask

  task automatic test_empty_message();
    send_item(8'($urandom), 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_single_bytes();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
  endtask

  // "abc" with ignored items in between
  task automatic test_abc_with_idle();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    hold_receiver(HOLD_CYCLES);
    for (int m = 0; m < 3; m++) begin
      for (int i = 0; i < 4; i++) send_item(8'($urandom), 1'b1, 1'b0);
      send_item(8'($urandom), 1'b1, 1'b1);
    end
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_messages(int unsigned n_items);
    int pad_lens[10] = '{55, 56, 57, 63, 64, 65, 119, 120, 128, 0};
    int unsigned start;
    int len;
    bit fin_last;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 2) == 0) len = pad_lens[$urandom_range(0, 9)];
      else len = $urandom_range(0, 24);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on <= ($urandom_range(0, 3) != 0);
      fin_last = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
        send_item(8'($urandom), 1'b1, fin_last && (i == len - 1));
      end
      if (!fin_last) send_item(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  initial begin
    sha1_restart();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_message();
    test_single_bytes();
    test_abc_with_idle();
    test_backpressure();
    test_random_messages(RANDOM_ITEMS);
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("hashed %0d messages from %0d input transactions", msgs_done, items_sent);
    $display("checked %0d digest words, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
